// File: sv/gap_pkg.sv
// ----------------------------------------------------------------------------
// gap_pkg
// shared constants and types for the global average pooling unit
// ----------------------------------------------------------------------------
package gap_pkg;

    // default sizing of the top level
    localparam int MAX_CHANNELS_DEF = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // register field widths
    localparam int NCH_W     = 7;
    localparam int POOL_W    = 17;
    localparam int RECIP_W   = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    // position counter and reciprocal fraction
    localparam int POS_W     = 16;
    localparam int FRAC_BITS = 16;

    // growth of a channel sum over the largest pool
    localparam int SUM_GROWTH = POS_W + 1;

    // output buffer depth, covers the arithmetic pipeline plus slack
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_CHANNELS = 2'd0,
        REG_POOL_SIZE    = 2'd1,
        REG_RECIPROCAL   = 2'd2
    } cfg_reg_t;

    // control tag travelling with a result through the pipeline
    typedef struct packed {
        logic valid;
        logic last_channel;
    } res_tag_t;

endpackage

// File: sv/gap_accum.sv
// ----------------------------------------------------------------------------
// gap_accum
// channel sum memory with read-modify-write, forwarding and batch counters
// ----------------------------------------------------------------------------
module gap_accum #(
    parameter int MAX_CHANNELS = gap_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = gap_pkg::SAMPLE_WIDTH_DEF,
    parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    parameter int SUM_W        = SAMPLE_WIDTH + gap_pkg::SUM_GROWTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
    input  logic [gap_pkg::NCH_W-1:0]      num_channels,
    input  logic [gap_pkg::POOL_W-1:0]     pool_size,
    output logic                           s1_pending,
    output gap_pkg::res_tag_t              acc_tag,
    output logic [CH_W-1:0]                acc_channel,
    output logic signed [SUM_W-1:0]        acc_sum
);

    localparam int CMP_W = (CH_W + 1 > gap_pkg::NCH_W) ? CH_W + 1 : gap_pkg::NCH_W;
    localparam int POS_W = gap_pkg::POS_W;

    // batch counters
    logic [CH_W-1:0]  chan_cnt_reg, chan_cnt_next;
    logic [POS_W-1:0] pos_cnt_reg, pos_cnt_next;

    // effective limits from the registers
    logic [CMP_W-1:0] nch_ext, nch_max, nch_eff, last_ch_full;
    logic [CH_W-1:0]  last_ch_idx, ch_sel;
    logic [POS_W-1:0] last_pos_idx;
    logic             is_last_ch, is_last_pos;

    // stage 1: read issued, sample waiting for its sum
    logic                           s1_valid_reg;
    logic [CH_W-1:0]                s1_ch_reg;
    logic                           s1_first_reg, s1_last_pos_reg, s1_last_ch_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample_reg;

    // sum memory and its forwarding path
    logic [SUM_W-1:0]        sums_mem [MAX_CHANNELS];
    logic [SUM_W-1:0]        rd_data_reg;
    logic                    fwd_valid_reg;
    logic [CH_W-1:0]         fwd_addr_reg;
    logic [SUM_W-1:0]        fwd_data_reg;
    logic signed [SUM_W-1:0] base_sum, sample_ext, wr_data;

    // result stage registers
    gap_pkg::res_tag_t       acc_tag_reg;
    logic [CH_W-1:0]         acc_ch_reg;
    logic signed [SUM_W-1:0] acc_sum_reg;

    // clamp channel count and pool size into range
    always_comb
    begin
        nch_ext = CMP_W'(num_channels);
        nch_max = CMP_W'(MAX_CHANNELS);
        if (nch_ext == '0)
            nch_eff = CMP_W'(1);
        else if (nch_ext > nch_max)
            nch_eff = nch_max;
        else
            nch_eff = nch_ext;
        last_ch_full = nch_eff - CMP_W'(1);
        last_ch_idx  = last_ch_full[CH_W-1:0];

        if (pool_size == '0)
            last_pos_idx = '0;
        else if (pool_size[gap_pkg::POOL_W-1])
            last_pos_idx = '1;
        else
            last_pos_idx = pool_size[POS_W-1:0] - POS_W'(1);
    end

    // current channel and batch position flags
    always_comb
    begin
        ch_sel      = (chan_cnt_reg > last_ch_idx) ? last_ch_idx : chan_cnt_reg;
        is_last_ch  = (ch_sel == last_ch_idx);
        is_last_pos = (pos_cnt_reg >= last_pos_idx);

        chan_cnt_next = chan_cnt_reg;
        pos_cnt_next  = pos_cnt_reg;
        if (in_valid)
        begin
            if (is_last_ch)
            begin
                chan_cnt_next = '0;
                pos_cnt_next  = is_last_pos ? '0 : pos_cnt_reg + POS_W'(1);
            end
            else
            begin
                chan_cnt_next = ch_sel + CH_W'(1);
            end
        end
    end

    // counters and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cnt_reg  <= '0;
            pos_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            acc_tag_reg   <= '0;
        end
        else
        begin
            chan_cnt_reg  <= chan_cnt_next;
            pos_cnt_reg   <= pos_cnt_next;
            s1_valid_reg  <= in_valid;
            fwd_valid_reg <= s1_valid_reg;
            acc_tag_reg.valid        <= s1_valid_reg && s1_last_pos_reg;
            acc_tag_reg.last_channel <= s1_last_ch_reg;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_ch_reg       <= ch_sel;
            s1_first_reg    <= (pos_cnt_reg == '0);
            s1_last_pos_reg <= is_last_pos;
            s1_last_ch_reg  <= is_last_ch;
            s1_sample_reg   <= in_sample;
        end
    end

    // add the sample to the stored or forwarded sum
    always_comb
    begin
        sample_ext = SUM_W'(s1_sample_reg);
        if (fwd_valid_reg && (fwd_addr_reg == s1_ch_reg))
            base_sum = fwd_data_reg;
        else
            base_sum = rd_data_reg;
        wr_data = s1_first_reg ? sample_ext : base_sum + sample_ext;
    end

    // sum memory, read before write on a shared address
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            sums_mem[s1_ch_reg] <= wr_data;
        if (in_valid)
            rd_data_reg <= sums_mem[ch_sel];
    end

    // last write kept for the item read in the same cycle
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            fwd_addr_reg <= s1_ch_reg;
            fwd_data_reg <= wr_data;
        end
    end

    // sum handed on for scaling
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            acc_ch_reg  <= s1_ch_reg;
            acc_sum_reg <= wr_data;
        end
    end

    assign s1_pending  = s1_valid_reg && s1_last_pos_reg;
    assign acc_tag     = acc_tag_reg;
    assign acc_channel = acc_ch_reg;
    assign acc_sum     = acc_sum_reg;

endmodule

// File: sv/gap_scale.sv
// ----------------------------------------------------------------------------
// gap_scale
// multiplies a channel sum by the reciprocal, floors and saturates
// ----------------------------------------------------------------------------
module gap_scale #(
    parameter int SAMPLE_WIDTH = gap_pkg::SAMPLE_WIDTH_DEF,
    parameter int CH_W         = 6,
    parameter int SUM_W        = SAMPLE_WIDTH + gap_pkg::SUM_GROWTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gap_pkg::res_tag_t              acc_tag,
    input  logic [CH_W-1:0]                acc_channel,
    input  logic signed [SUM_W-1:0]        acc_sum,
    input  logic [gap_pkg::RECIP_W-1:0]    reciprocal,
    output logic                           prod_pending,
    output gap_pkg::res_tag_t              res_tag,
    output logic [CH_W-1:0]                res_channel,
    output logic signed [SAMPLE_WIDTH-1:0] res_average
);

    localparam int PROD_W = SUM_W + gap_pkg::RECIP_W + 1;
    localparam int SH_W   = PROD_W - gap_pkg::FRAC_BITS;

    logic signed [gap_pkg::RECIP_W:0] recip_s;
    logic signed [PROD_W-1:0]         prod_next, prod_reg;
    gap_pkg::res_tag_t                tag_reg;
    logic [CH_W-1:0]                  ch_reg;
    logic [SH_W-1:0]                  shifted;
    logic [SH_W-SAMPLE_WIDTH:0]       top_bits;
    logic                             in_range;

    // signed product, reciprocal taken as a positive value
    assign recip_s   = {1'b0, reciprocal};
    assign prod_next = acc_sum * recip_s;

    // product stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else
            tag_reg <= acc_tag;
    end

    // product stage payload
    always_ff @(posedge clk)
    begin
        if (acc_tag.valid)
        begin
            prod_reg <= prod_next;
            ch_reg   <= acc_channel;
        end
    end

    // arithmetic shift gives the floor, then clamp to the sample range
    always_comb
    begin
        shifted  = prod_reg[PROD_W-1:gap_pkg::FRAC_BITS];
        top_bits = shifted[SH_W-1:SAMPLE_WIDTH-1];
        in_range = (top_bits == '0) || (top_bits == '1);
        if (in_range)
            res_average = shifted[SAMPLE_WIDTH-1:0];
        else if (shifted[SH_W-1])
            res_average = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else
            res_average = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end

    assign prod_pending = tag_reg.valid;
    assign res_tag      = tag_reg;
    assign res_channel  = ch_reg;

endmodule

// File: sv/gap_out_fifo.sv
// ----------------------------------------------------------------------------
// gap_out_fifo
// result buffer that parts the arithmetic pipeline from the output stream
// ----------------------------------------------------------------------------
module gap_out_fifo #(
    parameter int DATA_W = 23
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [DATA_W-1:0]             push_data,
    input  logic                          pop,
    output logic                          not_empty,
    output logic [DATA_W-1:0]             head_data,
    output logic [gap_pkg::OUT_CNT_W-1:0] count
);

    localparam int PTR_W = gap_pkg::OUT_PTR_W;
    localparam int CNT_W = gap_pkg::OUT_CNT_W;

    logic [DATA_W-1:0] buf_mem [gap_pkg::OUT_FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign do_pop = pop && (count_reg != '0);

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - CNT_W'(1);
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            buf_mem[wr_ptr_reg] <= push_data;
    end

    assign not_empty = (count_reg != '0);
    assign head_data = buf_mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// File: sv/global_average_pool_unit.sv
// ----------------------------------------------------------------------------
// global_average_pool_unit
// per-channel running sums over a batch, scaled to a floored mean
// ----------------------------------------------------------------------------
// Samples enter on the s_ stream, one word per cycle while s_tready is
// high, position by position with channels 0 .. num_channels-1 at each
// position. Each word does one read-modify-write of its channel's sum in
// a one-port-read, one-port-write memory; a one-entry forward path covers
// a write still in flight. During the last position of a batch each word
// yields one result on the m_ stream: the floored, saturated mean, its
// channel, and tlast on the final channel of the batch. Words of earlier
// positions yield nothing. Throughput is one word per cycle while s_tready
// is high, set by the single memory access per word. A result word passes
// the memory read, accumulate and multiply registers, then the output
// buffer, before it is offered. When m_tready is low, results collect in
// an eight-entry buffer; s_tready drops once buffered plus in-flight
// results fill it. Registers are written on the cfg_ channel, always ready,
// only while the block is idle, a rule for the user that the block does not
// enforce. Reset clears the counters, the pipeline and the buffer and loads
// num_channels 1, pool_size 1 and reciprocal 1.0; the sum memory needs no
// clearing since the first position of a batch overwrites it.
// ----------------------------------------------------------------------------
module global_average_pool_unit #(
    parameter int MAX_CHANNELS = gap_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH = gap_pkg::SAMPLE_WIDTH_DEF,
    parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    parameter int S_DATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8,
    parameter int M_DATA_W     = ((SAMPLE_WIDTH + CH_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gap_pkg::CFG_W-1:0]       cfg_data,
    // sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [S_DATA_W-1:0]             s_tdata,   // sample
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [M_DATA_W-1:0]             m_tdata,   // average, channel
    output logic                            m_tlast    // last_channel
);

    localparam int SUM_W    = SAMPLE_WIDTH + gap_pkg::SUM_GROWTH;
    localparam int RES_W    = SAMPLE_WIDTH + CH_W + 1;
    localparam int CREDIT_W = gap_pkg::OUT_CNT_W + 1;

    // configuration registers
    logic [gap_pkg::NCH_W-1:0]   num_channels_reg;
    logic [gap_pkg::POOL_W-1:0]  pool_size_reg;
    logic [gap_pkg::RECIP_W-1:0] reciprocal_reg;

    // pipeline links
    logic                           in_accept;
    logic                           s1_pending, prod_pending;
    gap_pkg::res_tag_t              acc_tag, res_tag;
    logic [CH_W-1:0]                acc_channel, res_channel;
    logic signed [SUM_W-1:0]        acc_sum;
    logic signed [SAMPLE_WIDTH-1:0] res_average;
    logic [RES_W-1:0]               push_data, head_data;
    logic [gap_pkg::OUT_CNT_W-1:0]  fifo_count;
    logic [CREDIT_W-1:0]            credits;

    // register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg <= gap_pkg::NCH_W'(1);
            pool_size_reg    <= gap_pkg::POOL_W'(1);
            reciprocal_reg   <= gap_pkg::RECIP_W'(1 << gap_pkg::FRAC_BITS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gap_pkg::REG_NUM_CHANNELS: num_channels_reg <= cfg_data[gap_pkg::NCH_W-1:0];
                gap_pkg::REG_POOL_SIZE:    pool_size_reg    <= cfg_data[gap_pkg::POOL_W-1:0];
                gap_pkg::REG_RECIPROCAL:   reciprocal_reg   <= cfg_data[gap_pkg::RECIP_W-1:0];
                default:                   ;
            endcase
        end
    end

    // input flow control: results in flight plus buffered stay within the buffer
    assign credits = CREDIT_W'(fifo_count) + CREDIT_W'(s1_pending)
                   + CREDIT_W'(acc_tag.valid) + CREDIT_W'(prod_pending);
    assign s_tready  = (credits < CREDIT_W'(gap_pkg::OUT_FIFO_DEPTH));
    assign in_accept = s_tvalid && s_tready;

    gap_accum #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CH_W         (CH_W),
        .SUM_W        (SUM_W)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_accept),
        .in_sample    (s_tdata[SAMPLE_WIDTH-1:0]),
        .num_channels (num_channels_reg),
        .pool_size    (pool_size_reg),
        .s1_pending   (s1_pending),
        .acc_tag      (acc_tag),
        .acc_channel  (acc_channel),
        .acc_sum      (acc_sum)
    );

    gap_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CH_W         (CH_W),
        .SUM_W        (SUM_W)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc_tag      (acc_tag),
        .acc_channel  (acc_channel),
        .acc_sum      (acc_sum),
        .reciprocal   (reciprocal_reg),
        .prod_pending (prod_pending),
        .res_tag      (res_tag),
        .res_channel  (res_channel),
        .res_average  (res_average)
    );

    // result word: average, channel, last flag
    assign push_data = {res_tag.last_channel, res_channel, res_average};

    gap_out_fifo #(
        .DATA_W    (RES_W)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_tag.valid),
        .push_data (push_data),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .head_data (head_data),
        .count     (fifo_count)
    );

    assign m_tdata = M_DATA_W'(head_data[SAMPLE_WIDTH+CH_W-1:0]);
    assign m_tlast = head_data[RES_W-1];

endmodule

// File: sv/gap_checker.sv
// ----------------------------------------------------------------------------
// gap_checker
// port-level checks on the global average pooling unit
// ----------------------------------------------------------------------------
module gap_checker #(
    parameter int M_DATA_W = 24
) (
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // input is only held off while results wait in the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    // input stalls only after results were already waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid))
        else $error("input stall began with empty result buffer");

    // a result on an empty output comes from an earlier accepted input word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
        else $error("result without a matching input word");

endmodule

bind global_average_pool_unit gap_checker #(
    .M_DATA_W (M_DATA_W)
) u_gap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: dv/gap_mean_checker.sv
// ----------------------------------------------------------------------------
// gap_mean_checker
// scoreboard for the global average pooling unit
// ----------------------------------------------------------------------------
// Watches the configuration, sample and result channels. Each accepted sample
// word runs through a behavioral copy of the channel sums and counters; words
// of the last position of a batch queue the expected mean word, and each
// accepted result word is compared field by field against the oldest entry.
// ----------------------------------------------------------------------------
module gap_mean_checker #(
    parameter int MAX_CH   = gap_pkg::MAX_CHANNELS_DEF,
    parameter int SW       = gap_pkg::SAMPLE_WIDTH_DEF,
    parameter int CH_W     = 6,
    parameter int S_DATA_W = 16,
    parameter int M_DATA_W = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [gap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gap_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [S_DATA_W-1:0]             s_tdata,   // sample
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [M_DATA_W-1:0]             m_tdata,   // average, channel
    input  logic                            m_tlast,   // last_channel
    input  logic                            end_of_test,
    output int                              errors,
    output int                              pending
);

    localparam longint AVG_MAX   = (longint'(1) << (SW - 1)) - 1;
    localparam longint AVG_MIN   = -AVG_MAX - 1;
    localparam int     POOL_MAX  = 1 << gap_pkg::POS_W;
    localparam int     MAX_SHOWN = 50;

    typedef struct packed {
        logic [SW-1:0]   average;
        logic [CH_W-1:0] channel;
        logic            last_channel;
    } mean_word_t;

    // shadow of the registers and of the accumulation state
    logic [gap_pkg::NCH_W-1:0]   nch_reg;
    logic [gap_pkg::POOL_W-1:0]  pool_reg;
    logic [gap_pkg::RECIP_W-1:0] recip_reg;
    longint                      channel_sums [MAX_CH];
    logic [gap_pkg::POS_W-1:0]   pos_cnt;
    logic [CH_W-1:0]             ch_cnt;

    mean_word_t expected_means [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string what);
        if (errors < MAX_SHOWN)
            $display("MISMATCH @%0t: %s", $time, what);
        errors++;
    endtask

    // one sample into its channel sum, queue a mean on the last position
    task automatic accumulate_sample(input logic [SW-1:0] raw);
        int         eff_nch;
        int         eff_pool;
        int         ch;
        bit         last_ch;
        bit         last_pos;
        longint     x;
        longint     scaled;
        mean_word_t w;
        eff_nch  = (nch_reg == 0) ? 1 : ((int'(nch_reg) > MAX_CH) ? MAX_CH : int'(nch_reg));
        eff_pool = (pool_reg == 0) ? 1
                 : ((int'(pool_reg) > POOL_MAX) ? POOL_MAX : int'(pool_reg));
        ch       = (int'(ch_cnt) > eff_nch - 1) ? eff_nch - 1 : int'(ch_cnt);
        last_ch  = (ch == eff_nch - 1);
        last_pos = (int'(pos_cnt) >= eff_pool - 1);
        x        = $signed(raw);

        // first position overwrites, later ones add
        if (pos_cnt == 0)
            channel_sums[ch] = x;
        else
            channel_sums[ch] = channel_sums[ch] + x;

        // advance channel, then position
        if (last_ch)
        begin
            ch_cnt  = '0;
            pos_cnt = last_pos ? '0 : pos_cnt + 1'b1;
        end
        else
        begin
            ch_cnt = CH_W'(ch + 1);
        end

        if (last_pos)
        begin
            // arithmetic shift floors toward minus infinity
            scaled = (channel_sums[ch] * longint'(recip_reg)) >>> gap_pkg::FRAC_BITS;
            if (scaled > AVG_MAX)
                scaled = AVG_MAX;
            else if (scaled < AVG_MIN)
                scaled = AVG_MIN;
            w.average      = SW'(scaled);
            w.channel      = CH_W'(ch);
            w.last_channel = last_ch;
            expected_means.push_back(w);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        mean_word_t want;
        if (!rst_n)
        begin
            nch_reg   = gap_pkg::NCH_W'(1);
            pool_reg  = gap_pkg::POOL_W'(1);
            recip_reg = gap_pkg::RECIP_W'(1 << gap_pkg::FRAC_BITS);
            pos_cnt   = '0;
            ch_cnt    = '0;
            expected_means.delete();
            pending   <= 0;
        end
        else
        begin
            // result words against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (expected_means.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected mean word %h last %b",
                                              m_tdata, m_tlast));
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (m_tdata[SW-1:0] !== want.average)
                        report_mismatch($sformatf("average %0d, want %0d (channel %0d)",
                                                  $signed(m_tdata[SW-1:0]),
                                                  $signed(want.average), want.channel));
                    if (m_tdata[SW+CH_W-1:SW] !== want.channel)
                        report_mismatch($sformatf("channel %0d, want %0d",
                                                  m_tdata[SW+CH_W-1:SW], want.channel));
                    if (m_tlast !== want.last_channel)
                        report_mismatch($sformatf("tlast %b, want %b (channel %0d)",
                                                  m_tlast, want.last_channel, want.channel));
                    if (m_tdata[M_DATA_W-1:SW+CH_W] !== '0)
                        report_mismatch($sformatf("padding bits %b not zero",
                                                  m_tdata[M_DATA_W-1:SW+CH_W]));
                end
            end

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gap_pkg::REG_NUM_CHANNELS: nch_reg   = cfg_data[gap_pkg::NCH_W-1:0];
                    gap_pkg::REG_POOL_SIZE:    pool_reg  = cfg_data[gap_pkg::POOL_W-1:0];
                    gap_pkg::REG_RECIPROCAL:   recip_reg = cfg_data[gap_pkg::RECIP_W-1:0];
                    default: ;
                endcase
            end

            // sample words
            if (s_tvalid && s_tready)
                accumulate_sample(s_tdata[SW-1:0]);

            // anything still queued at the end never arrived
            if (end_of_test)
            begin
                while (expected_means.size() != 0)
                begin
                    want = expected_means.pop_front();
                    report_mismatch($sformatf("missing mean word: average %0d channel %0d",
                                              $signed(want.average), want.channel));
                end
            end

            pending <= expected_means.size();
        end
    end

endmodule

// File: dv/tb_global_average_pool_unit.sv
// ----------------------------------------------------------------------------
// tb_global_average_pool_unit
// stimulus and verdict for the global average pooling unit
// ----------------------------------------------------------------------------
// A directed part hits sample extremes, flooring of negative means,
// saturation, out-of-range register values and registers changed in the
// middle of a batch. A random part then streams whole batches under many
// settings, mixed with cut-short batches that change registers midway and
// are flushed. Sender gaps and receiver stalls vary by phase; the checker
// module predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_global_average_pool_unit;

    localparam int SW           = gap_pkg::SAMPLE_WIDTH_DEF;
    localparam int MAX_CH       = gap_pkg::MAX_CHANNELS_DEF;
    localparam int CH_W         = $clog2(MAX_CH);
    localparam int S_DATA_W     = ((SW + 7) / 8) * 8;
    localparam int M_DATA_W     = ((SW + CH_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 700;
    localparam int SETTLE_CYC   = 8;
    localparam int QUIET_LIMIT  = 1000;
    localparam int SAMPLE_MAX   = (1 << (SW - 1)) - 1;
    localparam int SAMPLE_MIN   = -(1 << (SW - 1));
    localparam int RECIP_ONE    = 1 << gap_pkg::FRAC_BITS;
    localparam int CFG_MAX      = (1 << gap_pkg::CFG_W) - 1;
    localparam int NCH_MAX_RAW  = (1 << gap_pkg::NCH_W) - 1;

    // index with no register behind it
    localparam logic [gap_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [gap_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gap_pkg::CFG_W-1:0]      cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [S_DATA_W-1:0]            s_tdata;   // sample
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [M_DATA_W-1:0]            m_tdata;   // average, channel
    logic                           m_tlast;   // last_channel
    logic                           end_of_test;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    global_average_pool_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    gap_mean_checker #(
        .MAX_CH   (MAX_CH),
        .SW       (SW),
        .CH_W     (CH_W),
        .S_DATA_W (S_DATA_W),
        .M_DATA_W (M_DATA_W)
    ) u_mean_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .end_of_test (end_of_test),
        .errors      (errors),
        .pending     (pending)
    );

    // clock
    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one sample word, with random sender gaps ahead of it
    task automatic push_sample(input int value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(value);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // one register word; valid stays up for a following write
    task automatic write_reg(input logic [gap_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= gap_pkg::CFG_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // sel bits: num_channels, pool_size, reciprocal
    task automatic write_regs(input logic [2:0] sel, input int nch, input int pool,
                              input int recip);
        if (sel[0])
            write_reg(gap_pkg::REG_NUM_CHANNELS, nch);
        if (sel[1])
            write_reg(gap_pkg::REG_POOL_SIZE, pool);
        if (sel[2])
            write_reg(gap_pkg::REG_RECIPROCAL, recip);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, let every result drain, then allow for pipeline latency
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYC)
            @(posedge clk);
    endtask

    function automatic int random_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return SAMPLE_MAX;
        if (pick == 1)
            return SAMPLE_MIN;
        if (pick == 2)
            return int'($urandom_range(4)) - 2;
        return $urandom;
    endfunction

    initial
    begin : stimulus
        int sent;
        int phase;
        int nch;
        int pool;
        int recip;
        int eff_nch;
        int eff_pool;
        int cap;
        int n;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = gap_pkg::REG_NUM_CHANNELS;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        end_of_test = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: every sample is its own mean
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(0);
        push_sample(-1);

        // three channels over two positions at one half, negative floors
        settle();
        write_regs(3'b111, 3, 2, RECIP_ONE / 2);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(-1);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(0);

        // reciprocal above one saturates both ways
        settle();
        write_regs(3'b111, 1, 2, CFG_MAX);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MIN);

        // zero registers act as one, zero reciprocal gives zero
        settle();
        write_regs(3'b111, 0, 0, 0);
        push_sample(12345);
        push_sample(-5);

        // oversized registers, then shrink channels mid-batch
        settle();
        write_regs(3'b111, NCH_MAX_RAW, CFG_MAX, 1);
        push_sample(SAMPLE_MAX);
        push_sample(-300);
        push_sample(777);
        settle();
        write_reg(REG_UNUSED, CFG_MAX);
        write_regs(3'b011, 2, 1, 1);
        push_sample(-9);

        // pool size cut below the position already reached
        settle();
        write_regs(3'b111, 1, 5, 13107);
        push_sample(1000);
        push_sample(-3000);
        push_sample(20000);
        settle();
        write_regs(3'b010, 1, 2, 13107);
        push_sample(SAMPLE_MIN);

        // random batches over rotating idle phases
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            case (phase % 5)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 53; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 53; end
                3: begin send_idle_pct = 26; stall_pct <= 26; end
                default: begin send_idle_pct = 0; stall_pct <= 0; end
            endcase
            phase++;

            // pool size, mostly small
            n = $urandom_range(99);
            if (n < 5)
                pool = 0;
            else if (n < 60)
                pool = $urandom_range(1, 4);
            else if (n < 92)
                pool = $urandom_range(5, 16);
            else
                pool = $urandom_range(17, 64);
            eff_pool = (pool == 0) ? 1 : pool;

            // channels, keeping a batch at 128 words or less
            cap = 128 / eff_pool;
            if (cap > MAX_CH)
                cap = MAX_CH;
            n = $urandom_range(99);
            if (n < 5)
                nch = 0;
            else if (n < 10 && cap == MAX_CH)
                nch = $urandom_range(MAX_CH, NCH_MAX_RAW);
            else if (n < 65)
                nch = $urandom_range(1, (cap < 8) ? cap : 8);
            else
                nch = $urandom_range(1, cap);
            eff_nch = (nch == 0) ? 1 : ((nch > MAX_CH) ? MAX_CH : nch);

            // reciprocal near one over the pool, sometimes anything
            n = $urandom_range(99);
            if (n < 60)
                recip = (RECIP_ONE + eff_pool / 2) / eff_pool;
            else if (n < 85)
                recip = $urandom_range(0, CFG_MAX);
            else
                recip = $urandom_range(RECIP_ONE, CFG_MAX);

            write_regs(3'b111, nch, pool, recip);

            if ($urandom_range(99) < 80) begin
                // whole batches
                n = $urandom_range(1, 3) * eff_nch * eff_pool;
                repeat (n)
                    push_sample(random_sample());
                sent += n;
            end
            else begin
                // cut-short batch, registers changed midway, channels never grow
                n = $urandom_range(1, eff_nch * eff_pool);
                repeat (n)
                    push_sample(random_sample());
                sent += n;
                settle();
                nch  = $urandom_range(1, eff_nch);
                pool = ($urandom_range(9) == 0) ? CFG_MAX : $urandom_range(0, 8);
                write_regs(3'b111, nch, pool, $urandom_range(0, CFG_MAX));
                n = $urandom_range(0, 2 * nch);
                repeat (n)
                    push_sample(random_sample());
                sent += n;

                // flush back to the start of a batch
                settle();
                write_regs(3'b011, 1, 1, 0);
                push_sample(random_sample());
                sent++;
            end
        end

        // drain and verdict
        settle();
        end_of_test <= 1'b1;
        @(posedge clk);
        end_of_test <= 1'b0;
        @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
